// ===== rtl/core/sps_pkg.sv =====
package sps_pkg;

  // Shape kinds held in the shape_kind register.
  localparam logic [1:0] SHAPE_BOX      = 2'd0;
  localparam logic [1:0] SHAPE_SPHERE   = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd2;
  localparam logic [1:0] SHAPE_NONE     = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_KIND   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_QUAT   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_POS_X  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_POS_Y  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_POS_Z  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SIZE_A = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_SIZE_B = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SIZE_C = 3'd7;

  localparam logic [63:0] QUAT_IDENTITY = 64'h4000_0000_0000_0000;

  // Square root of a 64-bit sum: two bits of radicand per step.
  localparam int SQRT_STEPS = 32;
  // Quotient of the radius scaling never exceeds the 31-bit radius.
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // Quaternion lanes widened by one bit so a negated lane is exact.
  typedef struct packed {
    logic signed [16:0] w;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } quat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] quat;
    vec_t        pos;
    logic [30:0] size_a;
    logic [30:0] size_b;
    logic [30:0] size_c;
  } cfg_t;

  // Queue entry: body-frame direction and its squared length.
  typedef struct packed {
    vec_t        b;
    logic [63:0] s;
  } qent_t;

  // Sign information carried alongside the magnitudes in the back end.
  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] nz;
    logic       zl;
  } sgn_t;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v[43:31] == {13{v[43]}}) begin
      r = v[31:0];
    end else if (v[43]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Unpacks the register lanes; conj negates the vector part at full width.
  function automatic quat_t unpack_quat(input logic [63:0] raw, input logic conj);
    quat_t q;
    q.w = 17'(signed'(raw[63:48]));
    q.z = 17'(signed'(raw[47:32]));
    q.y = 17'(signed'(raw[31:16]));
    q.x = 17'(signed'(raw[15:0]));
    if (conj) begin
      q.x = -q.x;
      q.y = -q.y;
      q.z = -q.z;
    end
    return q;
  endfunction

endpackage

// ===== rtl/core/convex_shape_support_point_core.sv =====
// Throughput: one beat per cycle while the output is not stalled; the square root
// (32 stages) and the radius divider (31 stages) are fully pipelined, so no unit
// is shared between beats. A stall on the output holds the back end; the queue
// lets the front keep going until the queue is full.
// Reset (rst_n low, synchronous) empties all pipelines and the queue and loads
// the registers with a box of zero size at the origin, identity orientation.
module convex_shape_support_point_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sps_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [63:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_dir_x,
  input  logic signed [31:0]           in_dir_y,
  input  logic signed [31:0]           in_dir_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_support_x,
  output logic signed [31:0]           out_support_y,
  output logic signed [31:0]           out_support_z
);

  sps_pkg::cfg_t  cfg_r;
  sps_pkg::vec_t  dir;
  sps_pkg::vec_t  support;
  sps_pkg::qent_t q_wdata, q_rdata;
  logic           q_wr, q_rd, q_full, q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind   <= sps_pkg::SHAPE_BOX;
      cfg_r.quat   <= sps_pkg::QUAT_IDENTITY;
      cfg_r.pos    <= '0;
      cfg_r.size_a <= '0;
      cfg_r.size_b <= '0;
      cfg_r.size_c <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sps_pkg::CFG_KIND:   cfg_r.kind   <= cfg_wdata[1:0];
        sps_pkg::CFG_QUAT:   cfg_r.quat   <= cfg_wdata;
        sps_pkg::CFG_POS_X:  cfg_r.pos.x  <= cfg_wdata[31:0];
        sps_pkg::CFG_POS_Y:  cfg_r.pos.y  <= cfg_wdata[31:0];
        sps_pkg::CFG_POS_Z:  cfg_r.pos.z  <= cfg_wdata[31:0];
        sps_pkg::CFG_SIZE_A: cfg_r.size_a <= cfg_wdata[30:0];
        sps_pkg::CFG_SIZE_B: cfg_r.size_b <= cfg_wdata[30:0];
        sps_pkg::CFG_SIZE_C: cfg_r.size_c <= cfg_wdata[30:0];
        default:             cfg_r        <= cfg_r;
      endcase
    end
  end

  assign dir.x = in_dir_x;
  assign dir.y = in_dir_y;
  assign dir.z = in_dir_z;

  sps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .dir     (dir),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  sps_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .rd   (q_rd),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  sps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .support  (support)
  );

  assign out_support_x = support.x;
  assign out_support_y = support.y;
  assign out_support_z = support.z;

endmodule

// ===== rtl/core/sps_rot.sv =====
module sps_rot (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  sps_pkg::quat_t q,
  input  sps_pkg::vec_t  v,
  output logic          out_vld,
  output sps_pkg::vec_t  o
);

  logic signed [16:0] qw, qx, qy, qz;
  logic [3:0]         vld_r;

  logic signed [48:0] p_r [6];
  logic signed [48:0] p_nxt [6];
  logic signed [36:0] t_r [3];
  logic signed [36:0] t_nxt [3];
  logic signed [53:0] m_r [9];
  logic signed [53:0] m_nxt [9];
  sps_pkg::vec_t      v1_r, v2_r, v3_r, o_r, o_nxt;

  assign qw = q.w;
  assign qx = q.x;
  assign qy = q.y;
  assign qz = q.z;

  // Stage 1: cross product terms u x v.
  always_comb begin
    logic signed [31:0] vx, vy, vz;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    p_nxt[0] = qy * vz;
    p_nxt[1] = qz * vy;
    p_nxt[2] = qz * vx;
    p_nxt[3] = qx * vz;
    p_nxt[4] = qx * vy;
    p_nxt[5] = qy * vx;
  end

  // Stage 2: t = 2(u x v), rounded half up to Q16.16.
  always_comb begin
    logic signed [49:0] c;
    for (int i = 0; i < 3; i++) begin
      c = 50'(p_r[2*i]) - 50'(p_r[2*i+1]) + 50'sd4096;
      t_nxt[i] = c[49:13];
    end
  end

  // Stage 3: u x t and w * t.
  always_comb begin
    m_nxt[0] = qy * t_r[2];
    m_nxt[1] = qz * t_r[1];
    m_nxt[2] = qz * t_r[0];
    m_nxt[3] = qx * t_r[2];
    m_nxt[4] = qx * t_r[1];
    m_nxt[5] = qy * t_r[0];
    m_nxt[6] = qw * t_r[0];
    m_nxt[7] = qw * t_r[1];
    m_nxt[8] = qw * t_r[2];
  end

  // Stage 4: round, add the original vector and saturate.
  always_comb begin
    logic signed [55:0] a [3];
    logic signed [41:0] r [3];
    logic signed [31:0] vs [3];
    vs[0] = v3_r.x;
    vs[1] = v3_r.y;
    vs[2] = v3_r.z;
    for (int i = 0; i < 3; i++) begin
      a[i] = 56'(m_r[6+i]) + 56'(m_r[2*i]) - 56'(m_r[2*i+1]) + 56'sd8192;
      r[i] = a[i][55:14];
    end
    o_nxt.x = sps_pkg::sat32(44'(r[0]) + 44'(vs[0]));
    o_nxt.y = sps_pkg::sat32(44'(r[1]) + 44'(vs[1]));
    o_nxt.z = sps_pkg::sat32(44'(r[2]) + 44'(vs[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      v1_r <= v;
      t_r  <= t_nxt;
      v2_r <= v1_r;
      m_r  <= m_nxt;
      v3_r <= v2_r;
      o_r  <= o_nxt;
    end
  end

  assign out_vld = vld_r[3];
  assign o       = o_r;

endmodule

// ===== rtl/core/sps_fifo.sv =====
module sps_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  sps_pkg::qent_t wdata,
  input  logic           rd,
  output sps_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sps_pkg::qent_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/sps_front.sv =====
module sps_front (
  input  logic           clk,
  input  logic           rst_n,
  input  sps_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  sps_pkg::vec_t  dir,
  output logic           q_wr,
  output sps_pkg::qent_t q_wdata,
  input  logic           q_full
);

  logic           en_f;
  logic           rot_vld;
  sps_pkg::vec_t  rot_o;
  sps_pkg::quat_t qc;

  logic          sq_v_r;
  sps_pkg::vec_t b_r;
  logic [62:0]   sq_r [3];
  logic [62:0]   sq_nxt [3];

  // The pipe moves whenever its last stage is empty or drains into the queue.
  assign en_f     = !sq_v_r || !q_full;
  assign in_stall = !en_f;
  assign qc       = sps_pkg::unpack_quat(cfg.quat, 1'b1);

  // Rotate the direction into the body frame.
  sps_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en_f),
    .in_vld (in_valid),
    .q      (qc),
    .v      (dir),
    .out_vld(rot_vld),
    .o      (rot_o)
  );

  // Squares of the body-frame components.
  always_comb begin
    logic signed [31:0] c [3];
    logic signed [63:0] p;
    c[0] = rot_o.x;
    c[1] = rot_o.y;
    c[2] = rot_o.z;
    for (int i = 0; i < 3; i++) begin
      p = 64'(c[i]) * 64'(c[i]);
      sq_nxt[i] = p[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en_f) begin
      sq_v_r <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      b_r  <= rot_o;
      sq_r <= sq_nxt;
    end
  end

  // Classify: a sphere measures all three axes, every other kind (cylinder included) only xy.
  assign q_wr      = sq_v_r && !q_full;
  assign q_wdata.b = b_r;
  assign q_wdata.s = (cfg.kind == sps_pkg::SHAPE_SPHERE)
                   ? 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2])
                   : 64'(sq_r[0]) + 64'(sq_r[1]);

endmodule

// ===== rtl/core/sps_back.sv =====
module sps_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sps_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  sps_pkg::qent_t q_rdata,
  output logic           q_rd,
  output logic           out_valid,
  input  logic           out_stall,
  output sps_pkg::vec_t  support
);

  localparam int SQ_N = sps_pkg::SQRT_STEPS;
  localparam int DV_N = sps_pkg::DIV_STEPS;

  logic en_b;

  // Square root pipeline, one result bit per stage.
  logic [SQ_N:0]     sq_v_r;
  logic [63:0]       sq_n_r  [SQ_N+1];
  logic [63:0]       sq_rt_r [SQ_N+1];
  logic [2:0][31:0]  sq_m_r  [SQ_N+1];
  sps_pkg::sgn_t     sq_s_r  [SQ_N+1];
  logic [63:0]       sq_n_nxt  [SQ_N];
  logic [63:0]       sq_rt_nxt [SQ_N];
  logic [2:0][31:0]  mag0;
  sps_pkg::sgn_t     sgn0;

  // Magnitude times radius.
  logic              mu_v_r;
  logic [31:0]       mu_len_r;
  logic [2:0][62:0]  mu_p_r;
  sps_pkg::sgn_t     mu_s_r;

  // Restoring divider, one quotient bit per stage.
  logic [DV_N:0]     dv_v_r;
  logic [2:0][62:0]  dv_rem_r [DV_N+1];
  logic [2:0][30:0]  dv_q_r   [DV_N+1];
  logic [31:0]       dv_den_r [DV_N+1];
  sps_pkg::sgn_t     dv_s_r   [DV_N+1];
  logic [2:0][62:0]  dv_rem_nxt [DV_N];
  logic [2:0][30:0]  dv_q_nxt   [DV_N];

  // Local support point and world rotation.
  logic              lc_v_r;
  sps_pkg::vec_t     lc_r, lc_nxt;
  logic              rot_vld;
  sps_pkg::vec_t     rot_o;
  sps_pkg::quat_t    qw;

  logic              out_vld_r;
  sps_pkg::vec_t     out_r, out_nxt;

  // The whole back end advances when the output register can take a beat.
  assign en_b = !out_vld_r || !out_stall;
  assign q_rd = en_b && !q_empty;

  function automatic logic signed [31:0] signed_mag(input logic neg,
                                                    input logic [31:0] mag);
    logic signed [31:0] r;
    r = neg ? -$signed(mag) : $signed(mag);
    return r;
  endfunction

  // Split the queue head into magnitudes and signs.
  always_comb begin
    logic signed [31:0] c [3];
    logic signed [32:0] cw;
    logic signed [32:0] cn;
    c[0] = q_rdata.b.x;
    c[1] = q_rdata.b.y;
    c[2] = q_rdata.b.z;
    for (int i = 0; i < 3; i++) begin
      cw = 33'(c[i]);
      cn = -cw;
      mag0[i]     = cw[32] ? cn[31:0] : cw[31:0];
      sgn0.neg[i] = cw[32];
      sgn0.nz[i]  = (c[i] != 32'sd0);
    end
    sgn0.zl = (q_rdata.s == 64'd0);
  end

  // Integer square root steps.
  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_rt_r[k] + BIT;
    always_comb begin
      if (sq_n_r[k] >= trial) begin
        sq_n_nxt[k]  = sq_n_r[k] - trial;
        sq_rt_nxt[k] = (sq_rt_r[k] >> 1) + BIT;
      end else begin
        sq_n_nxt[k]  = sq_n_r[k];
        sq_rt_nxt[k] = sq_rt_r[k] >> 1;
      end
    end
  end

  // Division steps for all three lanes.
  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    localparam int J = DV_N - 1 - k;
    logic [62:0] sub;
    assign sub = 63'(dv_den_r[k]) << J;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[k][i] >= sub) begin
          dv_rem_nxt[k][i] = dv_rem_r[k][i] - sub;
          dv_q_nxt[k][i]   = dv_q_r[k][i] | (31'd1 << J);
        end else begin
          dv_rem_nxt[k][i] = dv_rem_r[k][i];
          dv_q_nxt[k][i]   = dv_q_r[k][i];
        end
      end
    end
  end

  // Pick the local support point for the shape.
  always_comb begin
    logic [2:0][31:0]   qt;
    logic signed [31:0] sc [3];
    logic signed [31:0] bx [3];
    logic [31:0]        half [3];
    sps_pkg::sgn_t      sg;
    sg      = dv_s_r[DV_N];
    half[0] = {2'b00, cfg.size_a[30:1]};
    half[1] = {2'b00, cfg.size_b[30:1]};
    half[2] = {2'b00, cfg.size_c[30:1]};
    for (int i = 0; i < 3; i++) begin
      qt[i] = {1'b0, dv_q_r[DV_N][i]};
      sc[i] = sg.zl ? 32'sd0 : signed_mag(sg.neg[i], qt[i]);
      bx[i] = sg.nz[i] ? signed_mag(sg.neg[i], half[i]) : 32'sd0;
    end
    unique case (cfg.kind)
      sps_pkg::SHAPE_BOX: begin
        lc_nxt.x = bx[0];
        lc_nxt.y = bx[1];
        lc_nxt.z = bx[2];
      end
      sps_pkg::SHAPE_SPHERE: begin
        lc_nxt.x = sc[0];
        lc_nxt.y = sc[1];
        lc_nxt.z = sc[2];
      end
      sps_pkg::SHAPE_CYLINDER: begin
        lc_nxt.x = sc[0];
        lc_nxt.y = sc[1];
        lc_nxt.z = sg.nz[2] ? signed_mag(sg.neg[2], half[1]) : 32'sd0;
      end
      sps_pkg::SHAPE_NONE: begin
        lc_nxt = '0;
      end
    endcase
  end

  // Valid bits of the square root, multiply, divider and local point stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      mu_v_r <= 1'b0;
      dv_v_r <= '0;
      lc_v_r <= 1'b0;
    end else if (en_b) begin
      sq_v_r <= {sq_v_r[SQ_N-1:0], !q_empty};
      mu_v_r <= sq_v_r[SQ_N];
      dv_v_r <= {dv_v_r[DV_N-1:0], mu_v_r};
      lc_v_r <= dv_v_r[DV_N];
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (en_b) begin
      sq_n_r[0]  <= q_rdata.s;
      sq_rt_r[0] <= '0;
      sq_m_r[0]  <= mag0;
      sq_s_r[0]  <= sgn0;
      for (int k = 0; k < SQ_N; k++) begin
        sq_n_r[k+1]  <= sq_n_nxt[k];
        sq_rt_r[k+1] <= sq_rt_nxt[k];
        sq_m_r[k+1]  <= sq_m_r[k];
        sq_s_r[k+1]  <= sq_s_r[k];
      end

      mu_len_r <= sq_rt_r[SQ_N][31:0];
      mu_s_r   <= sq_s_r[SQ_N];
      for (int i = 0; i < 3; i++) begin
        mu_p_r[i] <= 63'(sq_m_r[SQ_N][i]) * 63'(cfg.size_a);
      end

      // Numerator gets half the length for round-to-nearest.
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= mu_p_r[i] + 63'(mu_len_r[31:1]);
      end
      dv_q_r[0]   <= '0;
      dv_den_r[0] <= mu_len_r;
      dv_s_r[0]   <= mu_s_r;
      for (int k = 0; k < DV_N; k++) begin
        dv_rem_r[k+1] <= dv_rem_nxt[k];
        dv_q_r[k+1]   <= dv_q_nxt[k];
        dv_den_r[k+1] <= dv_den_r[k];
        dv_s_r[k+1]   <= dv_s_r[k];
      end

      lc_r <= lc_nxt;
    end
  end

  // Rotate the local point back into the world frame.
  assign qw = sps_pkg::unpack_quat(cfg.quat, 1'b0);

  sps_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en_b),
    .in_vld (lc_v_r),
    .q      (qw),
    .v      (lc_r),
    .out_vld(rot_vld),
    .o      (rot_o)
  );

  // Translate and saturate into the output register.
  always_comb begin
    logic signed [31:0] a [3];
    logic signed [31:0] p [3];
    a[0] = rot_o.x;
    a[1] = rot_o.y;
    a[2] = rot_o.z;
    p[0] = cfg.pos.x;
    p[1] = cfg.pos.y;
    p[2] = cfg.pos.z;
    out_nxt.x = sps_pkg::sat32(44'(a[0]) + 44'(p[0]));
    out_nxt.y = sps_pkg::sat32(44'(a[1]) + 44'(p[1]));
    out_nxt.z = sps_pkg::sat32(44'(a[2]) + 44'(p[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en_b) begin
      out_vld_r <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign support   = out_r;

endmodule

// ===== rtl/core/sps_checker.sv =====
module sps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_support_x,
  input logic [31:0] out_support_y,
  input logic [31:0] out_support_z
);

  logic        in_beat, out_beat;
  logic [15:0] inflight_r;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // Beats taken in and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending right after reset");

  // A result beat always belongs to an accepted input beat.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 16'd0)
    else $error("result beat without an accepted input beat");

  // An empty block never refuses an input beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 16'd0 |-> !in_stall)
    else $error("input stalled while nothing is in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_support_x)
      && $stable(out_support_y) && $stable(out_support_z))
    else $error("stalled result beat changed");

endmodule

bind convex_shape_support_point_core sps_checker u_sps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_support_x(out_support_x),
  .out_support_y(out_support_y),
  .out_support_z(out_support_z)
);
